// ===== rtl/core/tbtc_pkg.sv =====
// ----------------------------------------------------------------------------
// tbtc_pkg: shared types and constants for the Thumb branch target calculator
// Holds the instruction class codes, branch kind codes, address masks and the
// stage payload records passed between the decode, resolve and top modules.
// ----------------------------------------------------------------------------
package tbtc_pkg;

	// Branch kind codes on the result port
	localparam logic [1:0] KIND_NONE      = 2'd0;
	localparam logic [1:0] KIND_NOT_TAKEN = 2'd1;
	localparam logic [1:0] KIND_TAKEN     = 2'd2;

	// Condition field value that marks a software interrupt
	localparam logic [3:0] COND_SWI = 4'hf;

	// Target alignment masks
	localparam logic [31:0] HALF_ALIGN_MASK = 32'hffff_fffe;
	localparam logic [31:0] WORD_ALIGN_MASK = 32'hffff_fffc;

	// Opcode match fields
	localparam logic [3:0] OP_BCOND_TOP = 4'hd;
	localparam logic [4:0] OP_B_TOP     = 5'b11100;
	localparam logic [4:0] OP_BLX_TOP   = 5'b11101;
	localparam logic [4:0] OP_BL_TOP    = 5'b11111;
	localparam logic [7:0] OP_BXREG_HI  = 8'h47;
	localparam logic [7:0] OP_POPPC_HI  = 8'hbd;

	// ARM condition codes
	localparam logic [3:0] CC_EQ = 4'h0;
	localparam logic [3:0] CC_NE = 4'h1;
	localparam logic [3:0] CC_CS = 4'h2;
	localparam logic [3:0] CC_CC = 4'h3;
	localparam logic [3:0] CC_MI = 4'h4;
	localparam logic [3:0] CC_PL = 4'h5;
	localparam logic [3:0] CC_VS = 4'h6;
	localparam logic [3:0] CC_VC = 4'h7;
	localparam logic [3:0] CC_HI = 4'h8;
	localparam logic [3:0] CC_LS = 4'h9;
	localparam logic [3:0] CC_GE = 4'ha;
	localparam logic [3:0] CC_LT = 4'hb;
	localparam logic [3:0] CC_GT = 4'hc;
	localparam logic [3:0] CC_LE = 4'hd;

	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_BCOND,
		CLS_B,
		CLS_BL,
		CLS_BLX,
		CLS_BXREG,
		CLS_POP
	} br_class_t;

	// Decode stage record
	typedef struct packed {
		br_class_t   cls;
		logic        cond_ok;
		logic [31:0] base;
		logic [31:0] offset;
		logic [31:0] val;
		logic [31:0] sp;
		logic [3:0]  reg_cnt;
	} dec_t;

	// Address stage record
	typedef struct packed {
		br_class_t   cls;
		logic        cond_ok;
		logic [31:0] sum;
		logic [31:0] val;
		logic [31:0] slot;
	} addr_t;

	// Result record
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] target;
		logic        thumb;
		logic [31:0] slot;
	} res_t;

endpackage

// ===== rtl/core/tbtc_decode.sv =====
// ----------------------------------------------------------------------------
// tbtc_decode: opcode classification and operand selection
// Classifies the halfword, evaluates the condition, picks the adder operands
// and counts the listed low registers for POP.
// ----------------------------------------------------------------------------
module tbtc_decode import tbtc_pkg::*; (
	input  logic [15:0] opcode,
	input  logic [3:0]  cpsr_flags,
	input  logic [31:0] pc_value,
	input  logic [31:0] lr_value,
	input  logic [31:0] sp_value,
	input  logic [31:0] rm_value,
	input  logic [31:0] stacked_word,
	output dec_t        dec
);

	logic       n, z, c, v;
	logic [3:0] cond;
	logic       pass;
	logic [3:0] cnt;

	assign n    = cpsr_flags[3];
	assign z    = cpsr_flags[2];
	assign c    = cpsr_flags[1];
	assign v    = cpsr_flags[0];
	assign cond = opcode[11:8];

	always_comb begin
		unique case (cond)
			CC_EQ:   pass = z;
			CC_NE:   pass = !z;
			CC_CS:   pass = c;
			CC_CC:   pass = !c;
			CC_MI:   pass = n;
			CC_PL:   pass = !n;
			CC_VS:   pass = v;
			CC_VC:   pass = !v;
			CC_HI:   pass = c && !z;
			CC_LS:   pass = !c || z;
			CC_GE:   pass = (n == v);
			CC_LT:   pass = (n != v);
			CC_GT:   pass = !z && (n == v);
			CC_LE:   pass = z || (n != v);
			default: pass = 1'b1;
		endcase
	end

	// Count listed low registers
	always_comb begin
		cnt = 4'd0;
		for (int i = 0; i < 8; i++) begin
			cnt = cnt + {3'd0, opcode[i]};
		end
	end

	always_comb begin
		dec.cls     = CLS_NONE;
		dec.cond_ok = pass;
		dec.base    = 32'd0;
		dec.offset  = 32'd0;
		dec.val     = 32'd0;
		dec.sp      = sp_value;
		dec.reg_cnt = cnt;
		if (opcode[15:12] == OP_BCOND_TOP && cond != COND_SWI) begin
			dec.cls    = CLS_BCOND;
			dec.base   = pc_value;
			dec.offset = {{23{opcode[7]}}, opcode[7:0], 1'b0};
		end else if (opcode[15:11] == OP_B_TOP) begin
			dec.cls    = CLS_B;
			dec.base   = pc_value;
			dec.offset = {{20{opcode[10]}}, opcode[10:0], 1'b0};
		end else if (opcode[15:11] == OP_BL_TOP) begin
			dec.cls    = CLS_BL;
			dec.base   = lr_value;
			dec.offset = {20'd0, opcode[10:0], 1'b0};
		end else if (opcode[15:11] == OP_BLX_TOP) begin
			dec.cls    = CLS_BLX;
			dec.base   = lr_value;
			dec.offset = {20'd0, opcode[10:0], 1'b0};
		end else if (opcode[15:8] == OP_BXREG_HI && opcode[2:0] == 3'd0) begin
			dec.cls = CLS_BXREG;
			dec.val = rm_value;
		end else if (opcode[15:8] == OP_POPPC_HI) begin
			dec.cls = CLS_POP;
			dec.val = stacked_word;
		end
	end

endmodule

// ===== rtl/core/tbtc_resolve.sv =====
// ----------------------------------------------------------------------------
// tbtc_resolve: final result formation
// Turns the class and sums into branch kind, aligned target, Thumb state and
// the POP slot address.
// ----------------------------------------------------------------------------
module tbtc_resolve import tbtc_pkg::*; (
	input  addr_t ad,
	output res_t  res
);

	always_comb begin
		res.kind   = KIND_TAKEN;
		res.target = 32'd0;
		res.thumb  = 1'b1;
		res.slot   = 32'd0;
		unique case (ad.cls)
			CLS_NONE: begin
				res.kind = KIND_NONE;
			end
			CLS_BCOND: begin
				if (ad.cond_ok) begin
					res.target = ad.sum;
				end else begin
					res.kind = KIND_NOT_TAKEN;
				end
			end
			CLS_B, CLS_BL: begin
				res.target = ad.sum;
			end
			CLS_BLX: begin
				res.target = ad.sum & WORD_ALIGN_MASK;
				res.thumb  = 1'b0;
			end
			CLS_BXREG: begin
				res.target = ad.val & HALF_ALIGN_MASK;
				res.thumb  = ad.val[0];
			end
			CLS_POP: begin
				res.target = ad.val & HALF_ALIGN_MASK;
				res.thumb  = ad.val[0];
				res.slot   = ad.slot;
			end
			default: begin
				res.kind = KIND_NONE;
			end
		endcase
	end

endmodule

// ===== rtl/core/thumb_branch_target_calc.sv =====
// ----------------------------------------------------------------------------
// thumb_branch_target_calc: Thumb branch target calculator
// Classifies a Thumb halfword (conditional B, B, BL/BLX suffix, BX/BLX
// register, POP with PC) and reports branch kind, target, next Thumb state
// and POP slot address.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   in      | input     | in_valid/in_ready  | opcode, cpsr_flags, pc_value,
//           |           |                    | lr_value, sp_value, rm_value,
//           |           |                    | stacked_word
//   out     | output    | out_valid/out_ready| branch_kind, target_addr,
//           |           |                    | thumb_next, pop_slot_addr
//
// An item passes three register stages: decode into s1, the 32-bit target
// and slot adders into s2, result formation into s3, which is also the output
// register; out_valid is the s3 valid bit. One item is accepted per cycle when
// out_ready stays high. Reset clears the stage valid bits only. A stall on
// out_ready holds s3 and backs up through each stage, filling bubbles first, so
// no item is dropped or repeated.
// ----------------------------------------------------------------------------
module thumb_branch_target_calc import tbtc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] opcode,
	input  logic [3:0]  cpsr_flags,
	input  logic [31:0] pc_value,
	input  logic [31:0] lr_value,
	input  logic [31:0] sp_value,
	input  logic [31:0] rm_value,
	input  logic [31:0] stacked_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  branch_kind,
	output logic [31:0] target_addr,
	output logic        thumb_next,
	output logic [31:0] pop_slot_addr
);

	dec_t  dec;
	dec_t  dec_s1;
	addr_t addr_nxt;
	addr_t addr_s2;
	res_t  res;
	res_t  res_s3;
	logic  valid_s1, valid_s2, valid_s3;
	logic  ready_s1, ready_s2, ready_s3;

	// Each stage advances when empty or when the stage after it moves
	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Stage 1: classify and pick operands
	tbtc_decode u_decode (
		.opcode       (opcode),
		.cpsr_flags   (cpsr_flags),
		.pc_value     (pc_value),
		.lr_value     (lr_value),
		.sp_value     (sp_value),
		.rm_value     (rm_value),
		.stacked_word (stacked_word),
		.dec          (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			dec_s1 <= dec;
		end
	end

	// Stage 2: target sum and POP slot address, both wrapping
	always_comb begin
		addr_nxt.cls     = dec_s1.cls;
		addr_nxt.cond_ok = dec_s1.cond_ok;
		addr_nxt.sum     = dec_s1.base + dec_s1.offset;
		addr_nxt.val     = dec_s1.val;
		addr_nxt.slot    = dec_s1.sp + {26'd0, dec_s1.reg_cnt, 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			addr_s2 <= addr_nxt;
		end
	end

	// Stage 3: form the result; this register drives the output port
	tbtc_resolve u_resolve (
		.ad  (addr_s2),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			res_s3 <= res;
		end
	end

	assign out_valid     = valid_s3;
	assign branch_kind   = res_s3.kind;
	assign target_addr   = res_s3.target;
	assign thumb_next    = res_s3.thumb;
	assign pop_slot_addr = res_s3.slot;

	// Input backpressure only when every stage is full and the output stalls
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && valid_s3 && !out_ready))
		else $error("in_ready low while the pipeline has room");

	// An item moving out of s1 must show up in s2
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ready_s2) |=> valid_s2)
		else $error("item lost between s1 and s2");

	// A non-branch result carries a zero target and stays in Thumb
	a_none_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && branch_kind == KIND_NONE) |-> (target_addr == 32'd0 && thumb_next))
		else $error("non-branch result with nonzero target or ARM state");

	// Only a taken branch may report a POP slot address
	a_slot_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && branch_kind != KIND_TAKEN) |-> (pop_slot_addr == 32'd0))
		else $error("slot address on a result that is not a taken branch");

endmodule
